@@ sv/tksi_pkg.sv @@
package tksi_pkg;

  localparam int unsigned DEPTH_DEFAULT = 10;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  // Commands from the controller to the datapath; at most one is high per cycle.
  typedef struct packed {
    logic capture;
    logic start_scan;
    logic start_read;
    logic scan_step;
    logic place_zero;
    logic finish_read;
    logic finish_simple;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       fill_zero;
    logic       read_hit;
    logic       scan_greater;
    logic       cur_zero;
    logic       out_free;
  } stat_t;

endpackage

@@ sv/tksi_ctrl.sv @@
module tksi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tksi_pkg::stat_t stat_i,
  output tksi_pkg::cmd_t  cmd_o
);
  import tksi_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_PLACE  = 6'b001000,
    S_RDWAIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.req_type)
          REQ_INSERT: begin
            if (stat_i.fill_zero) begin
              cmd_o.place_zero = 1'b1;
              state_d          = S_DONE;
            end else begin
              cmd_o.start_scan = 1'b1;
              state_d          = S_SCAN;
            end
          end
          REQ_READ: begin
            if (stat_i.read_hit) begin
              cmd_o.start_read = 1'b1;
              state_d          = S_RDWAIT;
            end else begin
              cmd_o.finish_simple = 1'b1;
              state_d             = S_DONE;
            end
          end
          default: begin
            cmd_o.finish_simple = 1'b1;
            state_d             = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // The walk runs from the bottom of the list towards the top.
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_greater) begin
          state_d = S_DONE;
        end else if (stat_i.cur_zero) begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place_zero = 1'b1;
        state_d          = S_DONE;
      end
      S_RDWAIT: begin
        cmd_o.finish_read = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ sv/tksi_dpath.sv @@
module tksi_dpath #(
  parameter int unsigned DEPTH = tksi_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tksi_pkg::cmd_t     cmd_i,
  output tksi_pkg::stat_t    stat_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] new_score_i,
  input  logic [31:0]        player_tag_i,
  input  logic [3:0]         read_index_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               accepted_o,
  output logic [3:0]         insert_position_o,
  output logic [3:0]         count_now_o,
  output logic signed [31:0] entry_score_o,
  output logic [31:0]        entry_tag_o,
  output logic               entry_valid_o
);
  import tksi_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 4) ? CW : 4;

  logic [1:0]         req_q;
  logic signed [31:0] score_q;
  logic [31:0]        tag_q;
  logic [3:0]         ridx_q;

  logic [AW-1:0] cur_q, cur_d;
  logic [CW-1:0] fill_q, fill_d;

  logic signed [31:0] score_mem [DEPTH];
  logic [31:0]        tag_mem [DEPTH];
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_score;
  logic [31:0]        wr_tag;
  logic signed [31:0] rd_score_q;
  logic [31:0]        rd_tag_q;

  logic               pend_acc_q, pend_acc_d;
  logic [AW-1:0]      pend_pos_q, pend_pos_d;
  logic signed [31:0] pend_score_q, pend_score_d;
  logic [31:0]        pend_tag_q, pend_tag_d;
  logic               pend_valid_q, pend_valid_d;

  logic               out_valid_q;
  logic               out_acc_q;
  logic [3:0]         out_pos_q;
  logic [3:0]         out_cnt_q;
  logic signed [31:0] out_score_q;
  logic [31:0]        out_tag_q;
  logic               out_evalid_q;

  logic            cur_last;
  logic            cur_zero;
  logic            greater;
  logic            fill_room;
  logic [CMPW-1:0] ridx_ext;
  logic [CMPW-1:0] fill_ext;
  logic            out_free;

  assign cur_last  = (cur_q == AW'(DEPTH - 1));
  assign cur_zero  = (cur_q == '0);
  assign greater   = (rd_score_q > score_q);
  assign fill_room = (fill_q < CW'(DEPTH));
  assign ridx_ext  = CMPW'(ridx_q);
  assign fill_ext  = CMPW'(fill_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign stat_o.req_type     = req_q;
  assign stat_o.fill_zero    = (fill_q == '0);
  assign stat_o.read_hit     = (ridx_ext < fill_ext);
  assign stat_o.scan_greater = greater;
  assign stat_o.cur_zero     = cur_zero;
  assign stat_o.out_free     = out_free;

  always_comb begin
    cur_d        = cur_q;
    fill_d       = fill_q;
    rd_addr      = cur_q;
    wr_en        = 1'b0;
    wr_addr      = cur_q + AW'(1);
    wr_score     = rd_score_q;
    wr_tag       = rd_tag_q;
    pend_acc_d   = pend_acc_q;
    pend_pos_d   = pend_pos_q;
    pend_score_d = pend_score_q;
    pend_tag_d   = pend_tag_q;
    pend_valid_d = pend_valid_q;

    if (cmd_i.start_scan) begin
      cur_d   = AW'(fill_q - CW'(1));
      rd_addr = AW'(fill_q - CW'(1));
    end

    if (cmd_i.start_read) begin
      rd_addr = AW'(ridx_ext);
    end

    if (cmd_i.scan_step) begin
      if (greater) begin
        // Everything above this entry is greater too, so the new entry goes just below it.
        pend_valid_d = 1'b0;
        pend_score_d = '0;
        pend_tag_d   = '0;
        if (!cur_last) begin
          wr_en      = 1'b1;
          wr_score   = score_q;
          wr_tag     = tag_q;
          pend_acc_d = 1'b1;
          pend_pos_d = cur_q + AW'(1);
          if (fill_room) begin
            fill_d = fill_q + CW'(1);
          end
        end else begin
          pend_acc_d = 1'b0;
          pend_pos_d = '0;
        end
      end else begin
        // Move this entry down one rank; the last entry of a full list drops out.
        wr_en   = !cur_last;
        cur_d   = cur_q - AW'(1);
        rd_addr = cur_q - AW'(1);
      end
    end

    if (cmd_i.place_zero) begin
      wr_en        = 1'b1;
      wr_addr      = '0;
      wr_score     = score_q;
      wr_tag       = tag_q;
      pend_acc_d   = 1'b1;
      pend_pos_d   = '0;
      pend_valid_d = 1'b0;
      pend_score_d = '0;
      pend_tag_d   = '0;
      if (fill_room) begin
        fill_d = fill_q + CW'(1);
      end
    end

    if (cmd_i.finish_read) begin
      pend_acc_d   = 1'b0;
      pend_pos_d   = '0;
      pend_valid_d = 1'b1;
      pend_score_d = rd_score_q;
      pend_tag_d   = rd_tag_q;
    end

    if (cmd_i.finish_simple) begin
      pend_acc_d   = 1'b0;
      pend_pos_d   = '0;
      pend_valid_d = 1'b0;
      pend_score_d = '0;
      pend_tag_d   = '0;
      if (req_q == REQ_CLEAR) begin
        fill_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      score_mem[wr_addr] <= wr_score;
      tag_mem[wr_addr]   <= wr_tag;
    end
    rd_score_q <= score_mem[rd_addr];
    rd_tag_q   <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      score_q <= new_score_i;
      tag_q   <= player_tag_i;
      ridx_q  <= read_index_i;
    end
    cur_q        <= cur_d;
    pend_acc_q   <= pend_acc_d;
    pend_pos_q   <= pend_pos_d;
    pend_score_q <= pend_score_d;
    pend_tag_q   <= pend_tag_d;
    pend_valid_q <= pend_valid_d;
    if (cmd_i.push) begin
      out_acc_q    <= pend_acc_q;
      out_pos_q    <= 4'(pend_pos_q);
      out_cnt_q    <= 4'(fill_q);
      out_score_q  <= pend_score_q;
      out_tag_q    <= pend_tag_q;
      out_evalid_q <= pend_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign insert_position_o = out_pos_q;
  assign count_now_o       = out_cnt_q;
  assign entry_score_o     = out_score_q;
  assign entry_tag_o       = out_tag_q;
  assign entry_valid_o     = out_evalid_q;

endmodule

@@ sv/top_k_sorted_insert_unit.sv @@
// An insert walks the list from the bottom entry towards rank 0, at most DEPTH entries, and
// ends in a separate placement state when the score lands at rank 0 of a list that was not
// empty. One request is in work at a time; the next is taken the cycle after the result is
// registered. The walk makes one read and at most one write per cycle.
// Reset clears the entry count and control state only; list entries are not cleared.
module top_k_sorted_insert_unit #(
  parameter int unsigned DEPTH = tksi_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] new_score_i,
  input  logic [31:0]        player_tag_i,
  input  logic [3:0]         read_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [3:0]         insert_position_o,
  output logic [3:0]         count_now_o,
  output logic signed [31:0] entry_score_o,
  output logic [31:0]        entry_tag_o,
  output logic               entry_valid_o
);
  import tksi_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tksi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tksi_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_type_i        (req_type_i),
    .new_score_i       (new_score_i),
    .player_tag_i      (player_tag_i),
    .read_index_i      (read_index_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .accepted_o        (accepted_o),
    .insert_position_o (insert_position_o),
    .count_now_o       (count_now_o),
    .entry_score_o     (entry_score_o),
    .entry_tag_o       (entry_tag_o),
    .entry_valid_o     (entry_valid_o)
  );

endmodule

@@ sv/tksi_checker.sv @@
module tksi_checker #(
  parameter int unsigned DEPTH = tksi_pkg::DEPTH_DEFAULT
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               accepted_o,
  input logic [3:0]         insert_position_o,
  input logic [3:0]         count_now_o,
  input logic signed [31:0] entry_score_o,
  input logic [31:0]        entry_tag_o,
  input logic               entry_valid_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(accepted_o)
      && $stable(insert_position_o) && $stable(count_now_o)
      && $stable(entry_score_o) && $stable(entry_tag_o) && $stable(entry_valid_o))
    else $error("stalled result changed");

  // Only one request is in work, so a taken request must close the input.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input left open after a request was taken");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DEPTH > 15) || (count_now_o <= DEPTH))
    else $error("entry count beyond list depth");

  a_insert_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !entry_valid_o && (entry_score_o == 0)
      && (entry_tag_o == 0) && ((DEPTH > 15) || (insert_position_o < count_now_o)))
    else $error("inconsistent insert result");

  a_read_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_valid_o |-> !accepted_o && (insert_position_o == 0)
      && ((DEPTH > 15) || (count_now_o != 0)))
    else $error("inconsistent read result");

endmodule

bind top_k_sorted_insert_unit tksi_checker #(
  .DEPTH (DEPTH)
) u_tksi_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .accepted_o        (accepted_o),
  .insert_position_o (insert_position_o),
  .count_now_o       (count_now_o),
  .entry_score_o     (entry_score_o),
  .entry_tag_o       (entry_tag_o),
  .entry_valid_o     (entry_valid_o)
);

@@ test/top_k_sorted_insert_unit_test.sv @@
module top_k_sorted_insert_unit_test;
  import tksi_pkg::*;

  localparam int SLOTS = DEPTH_DEFAULT;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int PLAN_ROWS = 25;

  typedef struct packed {
    req_e        kind;
    logic [31:0] score;
    logic [31:0] tag;
    logic [3:0]  idx;
  } request_t;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  position;
    logic [3:0]  count;
    logic [31:0] score;
    logic [31:0] tag;
    logic        valid;
  } outcome_t;

  // A row carries a hand-written outcome only where typed is set.
  typedef struct packed {
    request_t rq;
    logic     typed;
    outcome_t want;
  } row_t;

  localparam row_t PLAN [PLAN_ROWS] = '{
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1,
      '{1'b0, 4'd0, 4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_CLEAR,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd9}, 1'b1,
      '{1'b0, 4'd0, 4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd0}, 1'b1,
      '{1'b1, 4'd0, 4'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_INSERT, 32'h8000_0000, 32'h0000_0000, 4'd0}, 1'b1,
      '{1'b1, 4'd1, 4'd2, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1,
      '{1'b0, 4'd0, 4'd2, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd1}, 1'b1,
      '{1'b0, 4'd0, 4'd2, 32'h8000_0000, 32'h0000_0000, 1'b1}},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd2}, 1'b1,
      '{1'b0, 4'd0, 4'd2, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_INSERT, 32'h0000_0000, 32'hA5A5_A5A5, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 4'd0}, 1'b0, '0},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd1}, 1'b0, '0},
    '{'{REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0064, 32'h0000_0002, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'hFFFF_FF9C, 32'h0000_0003, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0007, 32'h0000_0004, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0007, 32'h0000_0005, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h8000_0000, 32'h0000_0006, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h8000_0000, 32'h0000_0007, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0003, 32'h0000_0008, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h0000_0003, 32'h0000_0009, 4'd0}, 1'b0, '0},
    '{'{REQ_INSERT, 32'h8000_0000, 32'h0000_000C, 4'd0}, 1'b1,
      '{1'b0, 4'd0, 4'd10, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd9}, 1'b1,
      '{1'b0, 4'd0, 4'd10, 32'hFFFF_FF9C, 32'h0000_0003, 1'b1}},
    '{'{REQ_INSERT, 32'h7FFF_FFFF, 32'h0000_0000, 4'd0}, 1'b0, '0},
    '{'{REQ_CLEAR,  32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1,
      '{1'b0, 4'd0, 4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_READ,   32'h0000_0000, 32'h0000_0000, 4'd0}, 1'b1,
      '{1'b0, 4'd0, 4'd0, 32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{'{REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 4'd9}, 1'b1,
      '{1'b1, 4'd0, 4'd1, 32'h0000_0000, 32'h0000_0000, 1'b0}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i = REQ_READ;
  logic signed [31:0] new_score_i = '0;
  logic [31:0]        player_tag_i = '0;
  logic [3:0]         read_index_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               accepted_o;
  logic [3:0]         insert_position_o;
  logic [3:0]         count_now_o;
  logic signed [31:0] entry_score_o;
  logic [31:0]        entry_tag_o;
  logic               entry_valid_o;

  top_k_sorted_insert_unit #(.DEPTH(SLOTS)) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .req_type_i,
    .new_score_i,
    .player_tag_i,
    .read_index_i,
    .out_valid_o,
    .out_stall_i,
    .accepted_o,
    .insert_position_o,
    .count_now_o,
    .entry_score_o,
    .entry_tag_o,
    .entry_valid_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Own copy of the ranking.
  logic signed [31:0] board_score [SLOTS];
  logic [31:0]        board_tag [SLOTS];
  int                 board_fill = 0;

  row_t     request_q [$];
  outcome_t outcome_q [$];
  row_t     held;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_mismatch = 0;
  int       n_placed = 0;
  int       n_refused = 0;
  int       n_hits = 0;
  int       n_misses = 0;
  int       n_clears = 0;
  logic     steady;

  // Neither side idles during this stretch of requests.
  assign steady = (n_sent >= 500) && (n_sent < 800);

  function automatic outcome_t rank_apply(request_t rq);
    outcome_t r;
    int       pos;
    int       j;
    r = '0;
    case (rq.kind)
      REQ_INSERT: begin
        pos = 0;
        while (pos < board_fill && $signed(board_score[pos]) > $signed(rq.score))
          pos++;
        if (board_fill < SLOTS || pos < SLOTS) begin
          if (board_fill < SLOTS)
            board_fill++;
          for (j = board_fill - 1; j > pos; j--) begin
            board_score[j] = board_score[j - 1];
            board_tag[j]   = board_tag[j - 1];
          end
          board_score[pos] = rq.score;
          board_tag[pos]   = rq.tag;
          r.accepted = 1'b1;
          r.position = pos[3:0];
          n_placed++;
        end else begin
          n_refused++;
        end
      end
      REQ_READ: begin
        if (int'(rq.idx) < board_fill && int'(rq.idx) < SLOTS) begin
          r.valid = 1'b1;
          r.score = board_score[rq.idx];
          r.tag   = board_tag[rq.idx];
          n_hits++;
        end else begin
          n_misses++;
        end
      end
      REQ_CLEAR: begin
        board_fill = 0;
        n_clears++;
      end
      default: ;
    endcase
    r.count = board_fill[3:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_score();
    int unsigned r;
    r = $urandom_range(99);
    // Narrow ranges give plenty of equal scores.
    if (r < 40)
      return 32'($urandom_range(16)) - 32'd8;
    if (r < 70)
      return 32'($urandom_range(2000)) - 32'd1000;
    if (r < 80) begin
      case ($urandom_range(3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic row_t random_row(req_e kind, logic [3:0] idx);
    row_t w;
    w = '0;
    w.rq.kind  = kind;
    w.rq.score = pick_score();
    w.rq.tag   = $urandom();
    w.rq.idx   = idx;
    return w;
  endfunction

  function automatic void note_mismatch(string what, outcome_t want, outcome_t seen);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("MISMATCH %s: expected acc=%0d pos=%0d cnt=%0d score=%0d tag=%h ev=%0d, got acc=%0d pos=%0d cnt=%0d score=%0d tag=%h ev=%0d",
               what, want.accepted, want.position, want.count, $signed(want.score),
               want.tag, want.valid, seen.accepted, seen.position, seen.count,
               $signed(seen.score), seen.tag, seen.valid);
  endfunction

  // Request side: a request is taken at an edge with valid high and stall low.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = rank_apply(held.rq);
        outcome_q.push_back(held.typed ? held.want : want);
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (request_q.size() > 0 && (steady || $urandom_range(99) >= 21)) begin
          held = request_q.pop_front();
          req_type_i   <= held.rq.kind;
          new_score_i  <= held.rq.score;
          player_tag_i <= held.rq.tag;
          read_index_i <= held.rq.idx;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result side.
  always @(posedge clk_i) begin
    outcome_t seen;
    outcome_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.accepted = accepted_o;
        seen.position = insert_position_o;
        seen.count    = count_now_o;
        seen.score    = entry_score_o;
        seen.tag      = entry_tag_o;
        seen.valid    = entry_valid_o;
        if (outcome_q.size() == 0) begin
          note_mismatch("unexpected result", '0, seen);
        end else begin
          want = outcome_q.pop_front();
          n_checked++;
          if (seen.accepted !== want.accepted || seen.position !== want.position ||
              seen.count !== want.count || seen.score !== want.score ||
              seen.tag !== want.tag || seen.valid !== want.valid)
            note_mismatch($sformatf("result %0d", n_checked), want, seen);
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < 21);
    end
  end

  initial begin
    int unsigned r;
    int          k;
    foreach (PLAN[i])
      request_q.push_back(PLAN[i]);
    while (request_q.size() < PLAN_ROWS + RANDOM_REQUESTS) begin
      r = $urandom_range(99);
      if (r < 4) begin
        request_q.push_back(random_row(REQ_CLEAR, 4'($urandom_range(9))));
      end else if (r < 9) begin
        for (k = 0; k < SLOTS; k++)
          request_q.push_back(random_row(REQ_READ, 4'(k)));
      end else if (r < 60) begin
        request_q.push_back(random_row(REQ_INSERT, 4'($urandom_range(9))));
      end else begin
        request_q.push_back(random_row(REQ_READ, 4'($urandom_range(9))));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() > 0 || in_valid_i)
      @(posedge clk_i);
    while (outcome_q.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (outcome_q.size() > 0) begin
      n_mismatch++;
      $display("%0d expected results never arrived", outcome_q.size());
    end
    $display("Sent %0d requests: %0d inserts placed, %0d refused, %0d clears.",
             n_sent, n_placed, n_refused, n_clears);
    $display("Reads: %0d inside the list, %0d past its end; %0d results checked, %0d mismatches.",
             n_hits, n_misses, n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out waiting for the unit.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
